// ----- sv/egcd_pkg.sv -----
package egcd_pkg;
	localparam int DataWidth = 32;
	localparam int CntWidth = $clog2(DataWidth + 1);

	typedef struct packed {
		logic signed [DataWidth-1:0] operand_a;
		logic signed [DataWidth-1:0] operand_b;
	} egcd_in_t;

	typedef struct packed {
		logic signed [DataWidth-1:0] coef_s;
		logic signed [DataWidth-1:0] coef_t;
		logic signed [DataWidth-1:0] gcd_value;
		logic                        overflow;
	} egcd_out_t;

	// Classified work handed from the front to the back.
	typedef struct packed {
		logic                 a_neg;
		logic [DataWidth-1:0] a_mag;
		logic                 b_neg;
		logic [DataWidth-1:0] b_mag;
	} egcd_job_t;

	// Signed magnitude coefficient with saturation mark.
	typedef struct packed {
		logic                 neg;
		logic [DataWidth-1:0] mag;
		logic                 sat;
	} egcd_coef_t;

	function automatic logic [DataWidth-1:0] max_mag(input logic neg);
		logic [DataWidth-1:0] h;
		h = {1'b1, {(DataWidth-1){1'b0}}};
		return neg ? h : h - 1'b1;
	endfunction

	function automatic logic [DataWidth-1:0] to_field(input egcd_coef_t v);
		return v.neg ? (~v.mag + 1'b1) : v.mag;
	endfunction
endpackage

// ----- sv/extended_gcd_bezout.sv -----
// Extended Euclid unit: one word in, one word out.
// The input channel (in_valid/in_ready/in_word) takes a pair of signed
// operands; the output channel (out_valid/out_ready/out_word) returns the
// Bezout coefficients, the final nonzero remainder and an overflow flag.
// A front stage converts operands to sign and magnitude and parks them in a
// two-entry queue, so up to two words are taken while the back end works.
// The back end runs each Euclid iteration as a restoring division, then a
// multiply step and an update step; it takes a new word only once the
// result of the previous one has been accepted by the receiver.
// Reset clears the queue and the sequencer; no word is pending afterwards.
// When the receiver stalls, the result is held and the back end waits;
// the front keeps filling the queue until it is full.
module extended_gcd_bezout import egcd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  egcd_in_t  in_word,
	input  logic      in_valid,
	output logic      in_ready,
	output egcd_out_t out_word,
	output logic      out_valid,
	input  logic      out_ready
);
	egcd_job_t job;
	logic      job_valid, job_ready;

	egcd_front u_front (
		.clk, .arst_n, .in_word, .in_valid, .in_ready,
		.job, .job_valid, .job_ready
	);

	egcd_back u_back (
		.clk, .arst_n, .job, .job_valid, .job_ready,
		.out_word, .out_valid, .out_ready
	);
endmodule

// ----- sv/egcd_front.sv -----
module egcd_front import egcd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  egcd_in_t  in_word,
	input  logic      in_valid,
	output logic      in_ready,
	output egcd_job_t job,
	output logic      job_valid,
	input  logic      job_ready
);
	// Two-entry queue of classified jobs.
	egcd_job_t mem_q [2];
	logic      wp_q, rp_q;
	logic [1:0] cnt_q;
	egcd_job_t cj;

	always_comb begin
		cj.a_neg = in_word.operand_a[DataWidth-1];
		cj.a_mag = cj.a_neg ? (~in_word.operand_a + 1'b1) : in_word.operand_a;
		cj.b_neg = in_word.operand_b[DataWidth-1];
		cj.b_mag = cj.b_neg ? (~in_word.operand_b + 1'b1) : in_word.operand_b;
	end

	assign in_ready  = (cnt_q != 2'd2);
	assign job_valid = (cnt_q != 2'd0);
	assign job       = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) mem_q[wp_q] <= cj;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
		end else begin
			if (in_valid && in_ready) wp_q <= ~wp_q;
			if (job_valid && job_ready) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, in_valid && in_ready} - {1'b0, job_valid && job_ready};
		end
	end
endmodule

// ----- sv/egcd_back.sv -----
module egcd_back import egcd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  egcd_job_t job,
	input  logic      job_valid,
	output logic      job_ready,
	output egcd_out_t out_word,
	output logic      out_valid,
	input  logic      out_ready
);
	localparam int W = DataWidth;

	typedef enum logic [2:0] {S_IDLE, S_CHECK, S_DIV, S_MUL, S_UPD, S_DONE} st_t;
	st_t st_q;

	logic [W-1:0] r0m_q, r1m_q, rem_q, quo_q;
	logic         r0n_q, r1n_q;
	egcd_coef_t   s0_q, s1_q, t0_q, t1_q;
	logic [CntWidth-1:0] cnt_q;
	logic [2*W-1:0] ps_q, pt_q;
	logic         qneg_q, pvs_q, pvt_q;

	// One restoring division step.
	logic [W:0]   trial;
	logic [W-1:0] rem_sh;
	assign rem_sh = {rem_q[W-2:0], quo_q[W-1]};
	assign trial  = {rem_q, quo_q[W-1]} - {1'b0, r1m_q};

	function automatic egcd_coef_t upd(input egcd_coef_t x, input egcd_coef_t y,
		input logic qn, input logic [2*W-1:0] p, input logic big);
		egcd_coef_t r;
		logic pneg, dneg, rn, sat;
		logic [2*W:0] mag;
		sat  = x.sat | y.sat;
		pneg = (y.neg != qn) && (p != '0);
		dneg = !pneg;
		if (big) begin
			r.neg = !pneg; r.mag = max_mag(!pneg); r.sat = 1'b1;
			return r;
		end
		if (p == '0 || x.mag == '0 || x.neg == dneg) begin
			rn  = (x.mag != '0) ? x.neg : dneg;
			mag = {1'b0, p} + {{(W+1){1'b0}}, x.mag};
		end else if ({{W{1'b0}}, x.mag} >= p) begin
			rn  = x.neg;
			mag = {{(W+1){1'b0}}, x.mag} - {1'b0, p};
		end else begin
			rn  = dneg;
			mag = {1'b0, p} - {{(W+1){1'b0}}, x.mag};
		end
		if (mag > {{(W+1){1'b0}}, max_mag(rn)}) begin
			r.mag = max_mag(rn); sat = 1'b1;
		end else begin
			r.mag = mag[W-1:0];
		end
		r.neg = rn && (r.mag != '0);
		r.sat = sat;
		return r;
	endfunction

	assign job_ready = (st_q == S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			out_valid <= 1'b0;
		end else begin
			unique case (st_q)
				S_IDLE: begin
					if (job_valid) begin
						r0m_q <= job.a_mag; r0n_q <= job.a_neg;
						r1m_q <= job.b_mag; r1n_q <= job.b_neg;
						s0_q <= '{1'b0, W'(1), 1'b0}; s1_q <= '0;
						t0_q <= '0; t1_q <= '{1'b0, W'(1), 1'b0};
						st_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					if (r1m_q == '0) begin
						out_word.coef_s    <= to_field(s0_q);
						out_word.coef_t    <= to_field(t0_q);
						out_word.gcd_value <= r0n_q ? (~r0m_q + 1'b1) : r0m_q;
						out_word.overflow  <= s0_q.sat | t0_q.sat;
						out_valid <= 1'b1;
						st_q <= S_DONE;
					end else begin
						rem_q <= '0; quo_q <= r0m_q;
						cnt_q <= CntWidth'(W);
						st_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (!trial[W]) begin
						rem_q <= trial[W-1:0];
					end else begin
						rem_q <= rem_sh;
					end
					quo_q <= {quo_q[W-2:0], ~trial[W]};
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == CntWidth'(1)) st_q <= S_MUL;
				end
				S_MUL: begin
					qneg_q <= (quo_q != '0) && (r0n_q != r1n_q);
					ps_q <= s1_q.mag * quo_q;
					pt_q <= t1_q.mag * quo_q;
					pvs_q <= 1'b0; pvt_q <= 1'b0;
					st_q <= S_UPD;
				end
				S_UPD: begin
					s0_q <= s1_q; s1_q <= upd(s0_q, s1_q, qneg_q, ps_q, pvs_q);
					t0_q <= t1_q; t1_q <= upd(t0_q, t1_q, qneg_q, pt_q, pvt_q);
					r0m_q <= r1m_q; r0n_q <= r1n_q;
					r1m_q <= rem_q; r1n_q <= r0n_q && (rem_q != '0);
					st_q <= S_CHECK;
				end
				S_DONE: begin
					if (out_ready) begin
						out_valid <= 1'b0;
						st_q <= S_IDLE;
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end
endmodule

// ----- sv/egcd_checker.sv -----
module egcd_checker import egcd_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input egcd_in_t  in_word,
	input logic      in_valid,
	input logic      in_ready,
	input egcd_out_t out_word,
	input logic      out_valid,
	input logic      out_ready
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_word))
		else $error("result word changed while stalled");
	a_no_b2b: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready |=> !out_valid)
		else $error("result issued back to back");
	a_zero_b: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_word.gcd_value == '0 |-> out_word.coef_s == DataWidth'(1)
		&& out_word.coef_t == '0)
		else $error("zero gcd needs s=1 t=0");
endmodule

bind extended_gcd_bezout egcd_checker u_chk (.*);
